// ----- hdl/sed_pkg.sv -----
// Shared types and constants for the signed Euclidean divider.
// Used by sed_ctrl, sed_datapath and signed_euclidean_divider_unit; no dependencies.
`timescale 1ns / 1ps

package sed_pkg;

    // Operand width of dividend, divisor and quotient.
    localparam int DATA_WIDTH = 32;
    // Remainder width: the remainder always stays below 2^(DATA_WIDTH-1).
    localparam int REM_WIDTH  = DATA_WIDTH - 1;
    // Step counter over the quotient bits.
    localparam int CNT_WIDTH  = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(DATA_WIDTH - 1);

    // Stream payload widths, padded up to whole bytes.
    localparam int IN_FIELDS_W  = 2 * DATA_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_WIDTH + REM_WIDTH + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int STATUS_W     = 2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture operands and form magnitudes
        logic step;   // one restoring division step
        logic fix;    // Euclidean remainder and quotient correction
        logic fin;    // sign the quotient and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step;  // the current division step is the final one
    } t_dp_stat;

endpackage

// ----- hdl/sed_datapath.sv -----
// Datapath of the signed Euclidean divider: magnitude forming, radix-2
// restoring division, remainder fix-up and the output register. Uses sed_pkg.
`timescale 1ns / 1ps

module sed_datapath (
    input  logic                           i_clk,
    input  sed_pkg::t_cmd                  i_cmd,
    input  logic [sed_pkg::DATA_WIDTH-1:0] i_dividend,
    input  logic [sed_pkg::DATA_WIDTH-1:0] i_divisor,
    output sed_pkg::t_dp_stat              o_stat,
    output logic [sed_pkg::DATA_WIDTH-1:0] o_quotient,
    output logic [sed_pkg::REM_WIDTH-1:0]  o_remainder,
    output logic                           o_divisible,
    output sed_pkg::t_status               o_status
);
    import sed_pkg::*;

    localparam logic [DATA_WIDTH-1:0] LIMIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_mb, n_mb;
    logic                  r_a_neg, n_a_neg;
    logic                  r_b_neg, n_b_neg;
    logic                  r_b_zero, n_b_zero;
    logic                  r_q_neg, n_q_neg;
    logic [CNT_WIDTH-1:0]  r_count, n_count;

    logic [DATA_WIDTH-1:0] r_out_quo, n_out_quo;
    logic [REM_WIDTH-1:0]  r_out_rem, n_out_rem;
    logic                  r_out_div, n_out_div;
    t_status               r_out_st, n_out_st;

    logic                  a_neg_in;
    logic                  b_neg_in;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   trial;
    logic                  rem_nz;
    logic                  bump;
    logic [DATA_WIDTH-1:0] qmag_fix;
    logic                  qneg_fix;
    logic                  ovf;

    assign a_neg_in = i_dividend[DATA_WIDTH-1];
    assign b_neg_in = i_divisor[DATA_WIDTH-1];

    // One restoring step: shift in the next dividend bit and try the subtract.
    assign shifted = {r_rem, r_quo[DATA_WIDTH-1]};
    assign trial   = shifted - {1'b0, r_mb};

    // A negative dividend with a nonzero remainder moves the quotient one
    // step away from zero and reflects the remainder into [0, |b|).
    assign rem_nz   = (r_rem != '0);
    assign bump     = r_a_neg && rem_nz;
    assign qmag_fix = bump ? (r_quo + DATA_WIDTH'(1)) : r_quo;
    assign qneg_fix = (qmag_fix != '0) && (bump ? !r_b_neg : (r_a_neg != r_b_neg));

    // Overflow only when the positive quotient reaches 2^(DATA_WIDTH-1).
    assign ovf = r_q_neg ? (r_quo > LIMIT) : (r_quo >= LIMIT);

    assign o_stat.last_step = (r_count == CNT_LAST);

    // Next values of the working registers.
    always_comb begin
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_mb     = r_mb;
        n_a_neg  = r_a_neg;
        n_b_neg  = r_b_neg;
        n_b_zero = r_b_zero;
        n_q_neg  = r_q_neg;
        n_count  = r_count;
        if (i_cmd.load) begin
            n_rem    = '0;
            n_quo    = a_neg_in ? (~i_dividend + DATA_WIDTH'(1)) : i_dividend;
            n_mb     = b_neg_in ? (~i_divisor + DATA_WIDTH'(1)) : i_divisor;
            n_a_neg  = a_neg_in;
            n_b_neg  = b_neg_in;
            n_b_zero = (i_divisor == '0);
            n_count  = '0;
        end else if (i_cmd.step) begin
            n_rem   = trial[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            n_quo   = {r_quo[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
            n_count = r_count + CNT_WIDTH'(1);
        end else if (i_cmd.fix) begin
            n_quo   = qmag_fix;
            n_rem   = bump ? (r_mb - r_rem) : r_rem;
            n_q_neg = qneg_fix;
        end
    end

    // Next values of the output register.
    always_comb begin
        n_out_quo = r_out_quo;
        n_out_rem = r_out_rem;
        n_out_div = r_out_div;
        n_out_st  = r_out_st;
        if (i_cmd.fin) begin
            if (r_b_zero) begin
                n_out_quo = '0;
                n_out_rem = '0;
                n_out_div = 1'b0;
                n_out_st  = ST_DIV_ZERO;
            end else begin
                n_out_quo = r_q_neg ? (~r_quo + DATA_WIDTH'(1)) : r_quo;
                n_out_rem = r_rem[REM_WIDTH-1:0];
                n_out_div = !rem_nz;
                n_out_st  = ovf ? ST_OVERFLOW : ST_OK;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_mb      <= n_mb;
        r_a_neg   <= n_a_neg;
        r_b_neg   <= n_b_neg;
        r_b_zero  <= n_b_zero;
        r_q_neg   <= n_q_neg;
        r_count   <= n_count;
        r_out_quo <= n_out_quo;
        r_out_rem <= n_out_rem;
        r_out_div <= n_out_div;
        r_out_st  <= n_out_st;
    end

    assign o_quotient  = r_out_quo;
    assign o_remainder = r_out_rem;
    assign o_divisible = r_out_div;
    assign o_status    = r_out_st;

endmodule

// ----- hdl/sed_ctrl.sv -----
// Controller of the signed Euclidean divider: sequences load, division steps,
// fix-up and output, and owns the stream handshakes. Uses sed_pkg.
`timescale 1ns / 1ps

module sed_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sed_pkg::t_dp_stat i_stat,
    output sed_pkg::t_cmd     o_cmd
);
    import sed_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.last_step) n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and handshakes.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
            end
            S_FIN: begin
                o_cmd.fin = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The output register is full from a finish until its transfer.
    always_comb begin
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/signed_euclidean_divider_unit.sv -----
// Signed Euclidean divider, top level: stream ports around sed_ctrl and
// sed_datapath. Uses sed_pkg.
//
// Usage: a transfer on the slave channel carries a signed dividend and a
// signed divisor. The master channel returns one result per input: the
// Euclidean quotient, a remainder in [0, |divisor|), a divisible flag and a
// status code in tuser (ok, divisor zero, quotient overflow).
// A zero divisor gives zero quotient, remainder and divisible. The most
// negative dividend over minus one wraps the quotient and flags overflow.
// Sequence: the radix-2 restoring loop retires one quotient bit per cycle,
// then a fix-up state corrects quotient and remainder and an output state
// loads the output register, waiting while it still holds a result.
// One item is in the divider at a time: a new input is accepted only after
// the previous item has left the output state.
// The output register lets the next item be accepted and divided while a
// result still waits; when the receiver stalls, the divider holds its
// finished item until the output register frees up.
// Reset (synchronous, active low) empties the divider and the output register.
`timescale 1ns / 1ps

module signed_euclidean_divider_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: dividend, divisor.
    input  logic [sed_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0 up: quotient, remainder, divisible, zero padding.
    output logic [sed_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: status.
    output logic [sed_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import sed_pkg::*;

    t_cmd                  cmd;
    t_dp_stat              dp_stat;
    logic [DATA_WIDTH-1:0] quotient;
    logic [REM_WIDTH-1:0]  remainder;
    logic                  divisible;
    t_status               status;

    sed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_cmd       (cmd)
    );

    sed_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_dividend  (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_divisor   (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_stat      (dp_stat),
        .o_quotient  (quotient),
        .o_remainder (remainder),
        .o_divisible (divisible),
        .o_status    (status)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = OUT_TDATA_W'({divisible, remainder, quotient});
    assign m_axis_tuser = status;

endmodule
